/* rtl/rmth_pkg.sv */
package rmth_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int HEAP_DEPTH = 512;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int SIZE_W     = ADDR_W + 1;
    localparam int CNT_W      = SIZE_W + 1;
    localparam int MED_W      = SAMPLE_W + 1;

    localparam logic [CNT_W-1:0] TOTAL_CAP = CNT_W'(2 * HEAP_DEPTH);

    localparam logic HEAP_LO = 1'b0;  // max-heap of the lower half
    localparam logic HEAP_HI = 1'b1;  // min-heap of the upper half

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_UP_RD  = 7'b0000010,
        ST_UP_CMP = 7'b0000100,
        ST_DN_RDL = 7'b0001000,
        ST_DN_RDR = 7'b0010000,
        ST_DN_CMP = 7'b0100000,
        ST_FIN    = 7'b1000000
    } state_t;

    // True when a belongs above b in the heap selected by hi_heap.
    function automatic logic ahead(input logic signed [SAMPLE_W-1:0] a,
                                   input logic signed [SAMPLE_W-1:0] b,
                                   input logic hi_heap);
        ahead = hi_heap ? (a < b) : (a > b);
    endfunction

endpackage

/* rtl/rmth_ram.sv */
module rmth_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/running_median_two_heaps.sv */
// Running median over a stream of signed 16-bit samples, kept as two heaps:
// a max-heap of the lower half and a min-heap of the upper half, each in its
// own 512-entry single-port-read RAM.
// Input channel: s_valid/s_ready with s_sample. One item in flight at a time;
// s_ready is high only while the sequencer waits for the next item.
// Result channel: m_valid/m_ready with m_median_doubled (twice the median,
// lowest bit is the half), m_sample_count and m_rejected. One item per sample.
// Sequencing: a rejected sample goes from accept straight to loading the output
// register; otherwise one sift-down pass (read left child, read right child,
// compare at each level, when the larger half swaps its top) plus one sift-up
// pass (read parent, compare at each level).
// Each heap level waits on the registered RAM read before its compare.
// When both heaps hold 512 samples the sample is dropped, m_rejected is set
// and the median and count repeat unchanged.
// Reset clears sizes and median; RAM contents need no clearing since only
// entries below the current sizes are ever used.
// A stalled receiver holds the result in the output register; the sequencer
// waits in its final step until that register is free.
module running_median_two_heaps
    import rmth_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [MED_W-1:0]    m_median_doubled,
    output logic [CNT_W-1:0]           m_sample_count,
    output logic                       m_rejected
);

    state_t state_reg, state_next;

    logic [SIZE_W-1:0]          lo_n_reg, lo_n_next, hi_n_reg, hi_n_next;
    logic signed [MED_W-1:0]    med_reg, med_next;
    logic signed [SAMPLE_W-1:0] lo_top_reg, hi_top_reg;
    logic signed [SAMPLE_W-1:0] val_reg, val_next;   // value being sifted
    logic signed [SAMPLE_W-1:0] t_reg, t_next;       // top moving to other heap
    logic signed [SAMPLE_W-1:0] hl_reg, hl_next;     // left child
    logic [ADDR_W-1:0]          idx_reg, idx_next;   // hole position
    logic                       sel_reg, sel_next;   // heap being worked on
    logic                       move_reg, move_next; // push t after sift-down
    logic                       rej_reg, rej_next;

    logic                       m_valid_reg;
    logic signed [MED_W-1:0]    m_med_reg;
    logic [CNT_W-1:0]           m_cnt_reg;
    logic                       m_rej_reg;
    logic                       out_load;

    // shared RAM access
    logic                       we;
    logic [ADDR_W-1:0]          waddr, raddr;
    logic signed [SAMPLE_W-1:0] wdata;
    logic [SAMPLE_W-1:0]        lo_rdata, hi_rdata;
    logic signed [SAMPLE_W-1:0] rd;

    logic [CNT_W-1:0]           total;
    logic                       upward;
    logic [CNT_W-1:0]           l_w, r_w, n_cur;
    logic [ADDR_W-1:0]          parent;
    logic signed [SAMPLE_W-1:0] best_val;
    logic                       go_l, go_r;

    rmth_ram #(.WIDTH(SAMPLE_W), .DEPTH(HEAP_DEPTH)) u_lo_ram (
        .aclk  (aclk),
        .we    (we && (sel_reg == HEAP_LO)),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (lo_rdata)
    );

    rmth_ram #(.WIDTH(SAMPLE_W), .DEPTH(HEAP_DEPTH)) u_hi_ram (
        .aclk  (aclk),
        .we    (we && (sel_reg == HEAP_HI)),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (hi_rdata)
    );

    assign rd     = (sel_reg == HEAP_HI) ? $signed(hi_rdata) : $signed(lo_rdata);
    assign total  = CNT_W'(lo_n_reg) + CNT_W'(hi_n_reg);
    assign upward = $signed({s_sample, 1'b0}) > med_reg;
    assign l_w    = {1'b0, idx_reg, 1'b1};
    assign r_w    = l_w + CNT_W'(1);
    assign n_cur  = CNT_W'((sel_reg == HEAP_HI) ? hi_n_reg : lo_n_reg);
    assign parent = (idx_reg - ADDR_W'(1)) >> 1;

    // pick the child that wins over the hole value
    always_comb begin
        go_l     = (l_w < n_cur) && ahead(hl_reg, val_reg, sel_reg);
        best_val = go_l ? hl_reg : val_reg;
        go_r     = (r_w < n_cur) && ahead(rd, best_val, sel_reg);
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        lo_n_next  = lo_n_reg;
        hi_n_next  = hi_n_reg;
        med_next   = med_reg;
        val_next   = val_reg;
        t_next     = t_reg;
        hl_next    = hl_reg;
        idx_next   = idx_reg;
        sel_next   = sel_reg;
        move_next  = move_reg;
        rej_next   = rej_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = val_reg;
        raddr      = parent;
        out_load   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    rej_next  = 1'b0;
                    move_next = 1'b0;
                    val_next  = s_sample;
                    if (total >= TOTAL_CAP) begin
                        rej_next   = 1'b1;
                        state_next = ST_FIN;
                    end else if (hi_n_reg == lo_n_reg) begin
                        // plain push into the half the sample belongs to
                        sel_next   = upward;
                        state_next = ST_UP_RD;
                        if (upward) begin
                            idx_next  = hi_n_reg[ADDR_W-1:0];
                            hi_n_next = hi_n_reg + SIZE_W'(1);
                        end else begin
                            idx_next  = lo_n_reg[ADDR_W-1:0];
                            lo_n_next = lo_n_reg + SIZE_W'(1);
                        end
                    end else if (hi_n_reg > lo_n_reg) begin
                        if (upward && ahead(hi_top_reg, s_sample, HEAP_HI)) begin
                            // swap sample with the upper top, then move the top
                            sel_next   = HEAP_HI;
                            t_next     = hi_top_reg;
                            move_next  = 1'b1;
                            idx_next   = '0;
                            state_next = ST_DN_RDL;
                        end else begin
                            sel_next   = HEAP_LO;
                            idx_next   = lo_n_reg[ADDR_W-1:0];
                            lo_n_next  = lo_n_reg + SIZE_W'(1);
                            state_next = ST_UP_RD;
                        end
                    end else begin
                        if (!upward && ahead(lo_top_reg, s_sample, HEAP_LO)) begin
                            sel_next   = HEAP_LO;
                            t_next     = lo_top_reg;
                            move_next  = 1'b1;
                            idx_next   = '0;
                            state_next = ST_DN_RDL;
                        end else begin
                            sel_next   = HEAP_HI;
                            idx_next   = hi_n_reg[ADDR_W-1:0];
                            hi_n_next  = hi_n_reg + SIZE_W'(1);
                            state_next = ST_UP_RD;
                        end
                    end
                end
            end
            ST_UP_RD: begin
                if (idx_reg == '0) begin
                    we         = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                we = 1'b1;
                if (ahead(val_reg, rd, sel_reg)) begin
                    // pull parent down into the hole, climb
                    wdata      = rd;
                    idx_next   = parent;
                    state_next = ST_UP_RD;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_DN_RDL: begin
                raddr = l_w[ADDR_W-1:0];
                if (l_w >= n_cur) begin
                    we         = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_DN_RDR;
                end
            end
            ST_DN_RDR: begin
                raddr      = r_w[ADDR_W-1:0];
                hl_next    = rd;
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                we = 1'b1;
                if (go_r) begin
                    wdata      = rd;
                    idx_next   = r_w[ADDR_W-1:0];
                    state_next = ST_DN_RDL;
                end else if (go_l) begin
                    wdata      = hl_reg;
                    idx_next   = l_w[ADDR_W-1:0];
                    state_next = ST_DN_RDL;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (move_reg) begin
                    // push the displaced top into the other half
                    move_next  = 1'b0;
                    sel_next   = !sel_reg;
                    val_next   = t_reg;
                    state_next = ST_UP_RD;
                    if (sel_reg == HEAP_HI) begin
                        idx_next  = lo_n_reg[ADDR_W-1:0];
                        lo_n_next = lo_n_reg + SIZE_W'(1);
                    end else begin
                        idx_next  = hi_n_reg[ADDR_W-1:0];
                        hi_n_next = hi_n_reg + SIZE_W'(1);
                    end
                end else if (!m_valid_reg || m_ready) begin
                    if (!rej_reg) begin
                        if (lo_n_reg > hi_n_reg) begin
                            med_next = MED_W'({lo_top_reg, 1'b0});
                        end else if (hi_n_reg > lo_n_reg) begin
                            med_next = MED_W'({hi_top_reg, 1'b0});
                        end else begin
                            med_next = MED_W'(lo_top_reg) + MED_W'(hi_top_reg);
                        end
                    end
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            lo_n_reg    <= '0;
            hi_n_reg    <= '0;
            med_reg     <= '0;
            move_reg    <= 1'b0;
            rej_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            lo_n_reg  <= lo_n_next;
            hi_n_reg  <= hi_n_next;
            med_reg   <= med_next;
            move_reg  <= move_next;
            rej_reg   <= rej_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload and top-of-heap shadows
    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        t_reg   <= t_next;
        hl_reg  <= hl_next;
        idx_reg <= idx_next;
        sel_reg <= sel_next;
        if (we && waddr == '0) begin
            if (sel_reg == HEAP_HI) begin
                hi_top_reg <= wdata;
            end else begin
                lo_top_reg <= wdata;
            end
        end
        if (out_load) begin
            m_med_reg <= med_next;
            m_cnt_reg <= CNT_W'(lo_n_reg) + CNT_W'(hi_n_reg);
            m_rej_reg <= rej_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_median_doubled = m_med_reg;
    assign m_sample_count   = m_cnt_reg;
    assign m_rejected       = m_rej_reg;

endmodule

/* rtl/rmth_checker.sv */
module rmth_checker
    import rmth_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic signed [MED_W-1:0]    m_median_doubled,
    input logic [CNT_W-1:0]           m_sample_count,
    input logic                       m_rejected
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_median_doubled)
                                && $stable(m_sample_count))
        else $error("result dropped while stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in flight");

    a_reject_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rejected |-> m_sample_count == TOTAL_CAP)
        else $error("rejection with free space");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_sample_count <= TOTAL_CAP && m_sample_count != '0)
        else $error("sample count out of range");

endmodule

bind running_median_two_heaps rmth_checker u_rmth_checker (.*);
